>>> src/ctmu_pkg.sv
// ctmu_pkg: constants, codes and shared types of the complex matrix
// multiply-by-adjoint unit. No dependencies.
package ctmu_pkg;

    localparam int MATRIX_SIZE = 3;
    localparam int NELEM       = MATRIX_SIZE * MATRIX_SIZE;
    localparam int MEM_DEPTH   = 3 * NELEM;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 32;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 66;
    localparam int ACC_W       = 68;
    localparam int SACC_W      = 100;
    localparam int IN_W        = 104;
    localparam int OUT_W       = 72;

    typedef enum logic [1:0] {
        KIND_LOAD_A,
        KIND_LOAD_B,
        KIND_LOAD_C,
        KIND_COMPUTE
    } kind_t;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_SUB,
        MODE_SET,
        MODE_NONE
    } mode_t;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_RE_ADD,
        TAG_IM_ADD,
        TAG_IM_SUB,
        TAG_SC_LO,
        TAG_SC_MID,
        TAG_SC_HI
    } tag_t;

    typedef struct packed {
        tag_t                      tag;
        logic                      imag;
        logic signed [MUL_W-1:0]   a;
        logic signed [MUL_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        tag_t                      tag;
        logic                      imag;
        logic signed [PROD_W-1:0]  prod;
    } mul_res_t;

    // entry address: matrix select, then row-major element
    function automatic logic [ADDR_W-1:0] elem_addr(input kind_t sel,
                                                    input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        int unsigned t;
        t = int'(sel) * NELEM + int'(r) * MATRIX_SIZE + int'(c);
        return ADDR_W'(t);
    endfunction

endpackage

>>> src/complex_matrix_mul_adjoint_scaled_unit.sv
// Top level of the scaled complex multiply-by-adjoint unit: sequencer,
// accumulators, result stage. Depends on ctmu_pkg, ctmu_ram, ctmu_mul.
//
// A, B and C (side MATRIX_SIZE, Q15.16 complex) share one synchronous RAM
// with a single read and a single write port, and all products go through
// one registered 33x33 multiplier. Per inner step a compute beat does two
// RAM reads and four multiplies; per element it does a C read, six partial
// products of the scaling, clamp, combine and saturate, and it waits on
// any output stall. Results leave row by row, tlast on the last.
module complex_matrix_mul_adjoint_scaled_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // row[2:0] col[5:3] re[37:6] im[69:38] scale[101:70] mode[103:102]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // out_row[2:0] out_col[5:3] out_re[37:6] out_im[69:38] pad
    output logic [0:0]   m_tuser,   // saturated[0]
    output logic         m_tlast
);

    localparam int N   = ctmu_pkg::MATRIX_SIZE;
    localparam int IW  = ctmu_pkg::IDX_W;
    localparam int AW  = ctmu_pkg::ACC_W;
    localparam int SW  = ctmu_pkg::SACC_W;
    localparam int PW  = ctmu_pkg::PROD_W;
    localparam logic signed [AW-1:0] QMAX = 68'sh4000000000000000;
    localparam logic signed [AW-1:0] QMIN = -QMAX;
    localparam logic signed [63:0]   VMAX = 64'sh000000007fffffff;
    localparam logic signed [63:0]   VMIN = -64'sh0000000080000000;

    typedef enum logic [4:0] {
        S_IDLE, S_RDC, S_RDA, S_RDB, S_M0, S_M1, S_M2, S_M3,
        S_SC0, S_SC1, S_SC2, S_SC3, S_SC4, S_SC5, S_WT, S_CL, S_CMB, S_SAT
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0]  in_row, in_col;
    logic [31:0]    in_re, in_im, in_scale;
    ctmu_pkg::kind_t in_kind;
    ctmu_pkg::mode_t in_mode;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_re    = s_tdata[37:6];
    assign in_im    = s_tdata[69:38];
    assign in_scale = s_tdata[101:70];
    assign in_mode  = ctmu_pkg::mode_t'(s_tdata[103:102]);
    assign in_kind  = ctmu_pkg::kind_t'(s_tuser);

    logic [IW-1:0]   i_reg, j_reg, k_reg;
    logic [31:0]     scale_reg;
    ctmu_pkg::mode_t mode_reg;
    logic [31:0]     a_re_reg, a_im_reg, b_re_reg, b_im_reg, c_re_reg, c_im_reg;
    logic signed [AW-1:0] re_acc_reg, im_acc_reg;
    logic signed [SW-1:0] sr_acc_reg, si_acc_reg;
    logic signed [63:0]   pr_reg, pi_reg, vr_reg, vi_reg;

    logic                 out_valid_reg, out_sat_reg, out_last_reg;
    logic [IW-1:0]        out_row_reg, out_col_reg;
    logic [31:0]          out_re_reg, out_im_reg;

    logic                             mem_we;
    logic [ctmu_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [63:0]                      mem_wdata, mem_rdata;
    ctmu_pkg::mul_req_t               mul_req;
    ctmu_pkg::mul_res_t               mul_res;

    logic        adv, k_last, elem_last, in_range;
    logic [31:0] vr_sat, vi_sat;
    logic        clip;
    logic signed [AW-1:0] qr, qi;
    logic signed [SW-1:0] prod_ext;

    assign adv       = !out_valid_reg || m_tready;
    assign k_last    = k_reg == IW'(N - 1);
    assign elem_last = (i_reg == IW'(N - 1)) && (j_reg == IW'(N - 1));
    assign in_range  = ({1'b0, in_row} < 4'(N)) && ({1'b0, in_col} < 4'(N));
    assign s_tready  = state_reg == S_IDLE;

    ctmu_ram #(
        .DEPTH (ctmu_pkg::MEM_DEPTH),
        .WIDTH (64)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ctmu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res)
    );

    always_comb
    begin
        vr_sat = vr_reg[31:0];
        vi_sat = vi_reg[31:0];
        clip   = 1'b0;
        if (vr_reg > VMAX)
        begin
            vr_sat = 32'h7fffffff;
            clip   = 1'b1;
        end
        else if (vr_reg < VMIN)
        begin
            vr_sat = 32'h80000000;
            clip   = 1'b1;
        end
        if (vi_reg > VMAX)
        begin
            vi_sat = 32'h7fffffff;
            clip   = 1'b1;
        end
        else if (vi_reg < VMIN)
        begin
            vi_sat = 32'h80000000;
            clip   = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = ctmu_pkg::elem_addr(ctmu_pkg::KIND_LOAD_C, i_reg, j_reg);
        mem_wdata  = {vi_sat, vr_sat};
        mem_raddr  = ctmu_pkg::elem_addr(ctmu_pkg::KIND_LOAD_C, i_reg, j_reg);
        mul_req    = '{ctmu_pkg::TAG_NONE, 1'b0, '0, '0};
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_kind != ctmu_pkg::KIND_COMPUTE)
                    begin
                        mem_we    = in_range;
                        mem_waddr = ctmu_pkg::elem_addr(in_kind, in_row, in_col);
                        mem_wdata = {in_im, in_re};
                    end
                    else if (in_mode != ctmu_pkg::MODE_NONE)
                    begin
                        state_next = S_RDC;
                    end
                end
            end
            S_RDC: state_next = S_RDA;
            S_RDA:
            begin
                mem_raddr  = ctmu_pkg::elem_addr(ctmu_pkg::KIND_LOAD_A, i_reg, k_reg);
                state_next = S_RDB;
            end
            S_RDB:
            begin
                mem_raddr  = ctmu_pkg::elem_addr(ctmu_pkg::KIND_LOAD_B, j_reg, k_reg);
                state_next = S_M0;
            end
            S_M0:
            begin
                mul_req = '{ctmu_pkg::TAG_RE_ADD, 1'b0, {a_re_reg[31], a_re_reg},
                            {mem_rdata[31], mem_rdata[31:0]}};
                state_next = S_M1;
            end
            S_M1:
            begin
                mul_req = '{ctmu_pkg::TAG_RE_ADD, 1'b0, {a_im_reg[31], a_im_reg},
                            {b_im_reg[31], b_im_reg}};
                state_next = S_M2;
            end
            S_M2:
            begin
                mul_req = '{ctmu_pkg::TAG_IM_ADD, 1'b1, {a_im_reg[31], a_im_reg},
                            {b_re_reg[31], b_re_reg}};
                state_next = S_M3;
            end
            S_M3:
            begin
                mul_req = '{ctmu_pkg::TAG_IM_SUB, 1'b1, {a_re_reg[31], a_re_reg},
                            {b_im_reg[31], b_im_reg}};
                state_next = k_last ? S_SC0 : S_RDA;
            end
            S_SC0:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_LO, 1'b0, {1'b0, re_acc_reg[31:0]},
                            {scale_reg[31], scale_reg}};
                state_next = S_SC1;
            end
            S_SC1:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_MID, 1'b0, {1'b0, re_acc_reg[63:32]},
                            {scale_reg[31], scale_reg}};
                state_next = S_SC2;
            end
            S_SC2:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_HI, 1'b0,
                            {{29{re_acc_reg[AW-1]}}, re_acc_reg[AW-1:64]},
                            {scale_reg[31], scale_reg}};
                state_next = S_SC3;
            end
            S_SC3:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_LO, 1'b1, {1'b0, im_acc_reg[31:0]},
                            {scale_reg[31], scale_reg}};
                state_next = S_SC4;
            end
            S_SC4:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_MID, 1'b1, {1'b0, im_acc_reg[63:32]},
                            {scale_reg[31], scale_reg}};
                state_next = S_SC5;
            end
            S_SC5:
            begin
                mul_req = '{ctmu_pkg::TAG_SC_HI, 1'b1,
                            {{29{im_acc_reg[AW-1]}}, im_acc_reg[AW-1:64]},
                            {scale_reg[31], scale_reg}};
                state_next = S_WT;
            end
            S_WT:  state_next = S_CL;
            S_CL:  state_next = S_CMB;
            S_CMB: state_next = S_SAT;
            S_SAT:
            begin
                if (adv)
                begin
                    mem_we     = 1'b1;
                    state_next = elem_last ? S_IDLE : S_RDC;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state, indices and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            if (state_reg == S_M3)
            begin
                k_reg <= k_last ? '0 : k_reg + 1'b1;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_SAT && adv)
            begin
                out_valid_reg <= 1'b1;
                if (j_reg == IW'(N - 1))
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    assign qr = sr_acc_reg[SW-1:32];
    assign qi = si_acc_reg[SW-1:32];
    assign prod_ext = {{(SW-PW){mul_res.prod[PW-1]}}, mul_res.prod};

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            scale_reg <= in_scale;
            mode_reg  <= in_mode;
        end
        if (state_reg == S_RDA && k_reg == '0)
        begin
            c_re_reg <= mem_rdata[31:0];
            c_im_reg <= mem_rdata[63:32];
        end
        if (state_reg == S_RDB)
        begin
            a_re_reg <= mem_rdata[31:0];
            a_im_reg <= mem_rdata[63:32];
        end
        if (state_reg == S_M0)
        begin
            b_re_reg <= mem_rdata[31:0];
            b_im_reg <= mem_rdata[63:32];
        end
        if (state_reg == S_RDC)
        begin
            re_acc_reg <= '0;
            im_acc_reg <= '0;
            sr_acc_reg <= '0;
            si_acc_reg <= '0;
        end
        else
        begin
            case (mul_res.tag)
                ctmu_pkg::TAG_RE_ADD: re_acc_reg <= re_acc_reg + prod_ext[AW-1:0];
                ctmu_pkg::TAG_IM_ADD: im_acc_reg <= im_acc_reg + prod_ext[AW-1:0];
                ctmu_pkg::TAG_IM_SUB: im_acc_reg <= im_acc_reg - prod_ext[AW-1:0];
                ctmu_pkg::TAG_SC_LO:
                begin
                    if (mul_res.imag) si_acc_reg <= si_acc_reg + prod_ext;
                    else              sr_acc_reg <= sr_acc_reg + prod_ext;
                end
                ctmu_pkg::TAG_SC_MID:
                begin
                    if (mul_res.imag) si_acc_reg <= si_acc_reg + (prod_ext <<< 32);
                    else              sr_acc_reg <= sr_acc_reg + (prod_ext <<< 32);
                end
                ctmu_pkg::TAG_SC_HI:
                begin
                    if (mul_res.imag) si_acc_reg <= si_acc_reg + (prod_ext <<< 64);
                    else              sr_acc_reg <= sr_acc_reg + (prod_ext <<< 64);
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_CL)
        begin
            pr_reg <= (qr > QMAX) ? QMAX[63:0] : ((qr < QMIN) ? QMIN[63:0] : qr[63:0]);
            pi_reg <= (qi > QMAX) ? QMAX[63:0] : ((qi < QMIN) ? QMIN[63:0] : qi[63:0]);
        end
        if (state_reg == S_CMB)
        begin
            case (mode_reg)
                ctmu_pkg::MODE_ADD:
                begin
                    vr_reg <= {{32{c_re_reg[31]}}, c_re_reg} + pr_reg;
                    vi_reg <= {{32{c_im_reg[31]}}, c_im_reg} + pi_reg;
                end
                ctmu_pkg::MODE_SUB:
                begin
                    vr_reg <= {{32{c_re_reg[31]}}, c_re_reg} - pr_reg;
                    vi_reg <= {{32{c_im_reg[31]}}, c_im_reg} - pi_reg;
                end
                default:
                begin
                    vr_reg <= pr_reg;
                    vi_reg <= pi_reg;
                end
            endcase
        end
        if (state_reg == S_SAT && adv)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_re_reg   <= vr_sat;
            out_im_reg   <= vi_sat;
            out_sat_reg  <= clip;
            out_last_reg <= elem_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_im_reg, out_re_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDC |-> mul_res.tag == ctmu_pkg::TAG_NONE)
        else $error("product in flight across element start");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAT && adv) |=> out_valid_reg)
        else $error("result beat not presented");

    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_IDLE) |-> state_reg == S_SAT)
        else $error("store write outside load or writeback");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, k_reg} < 4'(N)) && ({1'b0, i_reg} < 4'(N) || state_reg == S_IDLE)
        && ({1'b0, j_reg} < 4'(N)))
        else $error("index beyond matrix side");
`endif

endmodule

>>> src/ctmu_ram.sv
// ctmu_ram: generic single-port-write, single-port-read synchronous RAM,
// read data registered. No dependencies.
module ctmu_ram #(
    parameter int DEPTH = 27,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ctmu_mul.sv
// ctmu_mul: shared registered 33x33 signed multiplier; the request tag
// travels with the product. Depends on ctmu_pkg.
module ctmu_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  ctmu_pkg::mul_req_t req,
    output ctmu_pkg::mul_res_t res
);

    ctmu_pkg::tag_t                         tag_reg;
    logic                                   imag_reg;
    logic signed [ctmu_pkg::PROD_W-1:0]     prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= ctmu_pkg::TAG_NONE;
            imag_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= req.tag;
            imag_reg <= req.imag;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign res.tag  = tag_reg;
    assign res.imag = imag_reg;
    assign res.prod = prod_reg;

endmodule
